[src/assert_macros.svh]
// Assertion macros for the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, disabled while arst_n is low.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("concurrent assertion failed");

// Same check with a message of the caller's choosing.
`define ASSERT_CLK_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

[src/ibmh_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Request and response types, operation and status codes, and the command
// and status groups exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package ibmh_pkg;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  node_id;
		logic [31:0] node_key;
	} req_t;

	typedef struct packed {
		logic [7:0]  out_id;
		logic [31:0] out_key;
		logic [2:0]  status;
		logic [8:0]  entry_count;
	} rsp_t;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EMPTY  = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_ABSENT = 3'd3;
	localparam logic [2:0] ST_DUP    = 3'd4;

	localparam logic [3:0] CMD_NOP     = 4'd0;
	localparam logic [3:0] CMD_LOAD    = 4'd1;
	localparam logic [3:0] CMD_LOOK    = 4'd2;
	localparam logic [3:0] CMD_INS     = 4'd3;
	localparam logic [3:0] CMD_EXT     = 4'd4;
	localparam logic [3:0] CMD_REM     = 4'd5;
	localparam logic [3:0] CMD_REM_LD  = 4'd6;
	localparam logic [3:0] CMD_UP_REQ  = 4'd7;
	localparam logic [3:0] CMD_UP_MOVE = 4'd8;
	localparam logic [3:0] CMD_DN_REQ  = 4'd9;
	localparam logic [3:0] CMD_DN_L    = 4'd10;
	localparam logic [3:0] CMD_DN_R    = 4'd11;
	localparam logic [3:0] CMD_DN_MOVE = 4'd12;
	localparam logic [3:0] CMD_PLACE   = 4'd13;
	localparam logic [3:0] CMD_FIN     = 4'd14;

	typedef struct packed {
		logic [3:0] code;
		logic [2:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       id_ok;
		logic       present;
		logic       full;
		logic       empty;
		logic       last_zero;
		logic       slot_lt_last;
		logic       slot_zero;
		logic       moved;
		logic       cur_lt_rd;
		logic       left_lt_fill;
		logic       right_lt_fill;
		logic       best_lt_cur;
	} dp_sts_t;

endpackage

[src/ibmh_dp.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap datapath
// Heap and position memories, fill count, the moving entry and the compare
// logic used by sift-up and sift-down.
// ----------------------------------------------------------------------------
module ibmh_dp #(
	parameter int CAPACITY  = 256,
	parameter int ID_SPACE  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ibmh_pkg::req_t   in_data,
	input  ibmh_pkg::dp_cmd_t cmd,
	output ibmh_pkg::dp_sts_t sts,
	output ibmh_pkg::rsp_t   out_data
);
	import ibmh_pkg::*;

	localparam int IW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int KW = KEY_WIDTH;
	localparam int CW = PW + 2;

	typedef struct packed {
		logic [IW-1:0] id;
		logic [KW-1:0] key;
	} ent_t;

	ent_t          heap_mem [CAPACITY];
	logic [PW-1:0] pos_mem  [ID_SPACE];

	ent_t          h_rd_q;
	logic [PW-1:0] p_rd_q;

	req_t          req_q;
	logic [FW-1:0] fill_q;
	logic [PW-1:0] slot_q;
	ent_t          cur_q;
	ent_t          best_q;
	logic [PW-1:0] best_idx_q;
	ent_t          root_q;
	logic          res_ok_q;
	logic          moved_q;
	rsp_t          out_q;

	logic [PW-1:0] h_raddr;
	logic          h_we;
	logic [PW-1:0] h_waddr;
	ent_t          h_wdata;
	logic          p_we;
	logic [IW-1:0] p_waddr;
	logic [PW-1:0] p_wdata;

	logic [16:0]   req_id_w;
	logic [16:0]   in_id_w;
	logic [IW-1:0] req_idx;
	logic [IW-1:0] in_idx;
	logic [FW-1:0] last_w;
	logic [PW-1:0] last;
	logic [PW-1:0] parent;
	logic [CW-1:0] left_w;
	logic [CW-1:0] right_w;
	logic [CW-1:0] fill_w;
	logic [CW-1:0] slot_w;
	logic [63:0]   key_in_w;
	ent_t          ins_ent;

	assign req_id_w = 17'(req_q.node_id);
	assign in_id_w  = 17'(in_data.node_id);
	assign req_idx  = req_id_w[IW-1:0];
	assign in_idx   = in_id_w[IW-1:0];
	assign last_w   = fill_q - FW'(1);
	assign last     = last_w[PW-1:0];
	assign parent   = (slot_q - PW'(1)) >> 1;
	assign left_w   = {1'b0, slot_q, 1'b1};
	assign right_w  = {1'b0, slot_q, 1'b0} + CW'(2);
	assign fill_w   = CW'(fill_q);
	assign slot_w   = CW'(slot_q);
	assign key_in_w = 64'(req_q.node_key);
	assign ins_ent  = '{id: req_idx, key: key_in_w[KW-1:0]};

	always_comb begin
		h_raddr = '0;
		h_we    = 1'b0;
		h_waddr = slot_q;
		h_wdata = cur_q;
		p_we    = 1'b0;
		p_waddr = cur_q.id;
		p_wdata = slot_q;
		case (cmd.code)
			CMD_LOOK: begin
				h_raddr = (req_q.opcode == OP_EXTRACT) ? last : p_rd_q;
			end
			CMD_REM:    h_raddr = last;
			CMD_UP_REQ: h_raddr = parent;
			CMD_DN_REQ: h_raddr = left_w[PW-1:0];
			CMD_DN_L:   h_raddr = right_w[PW-1:0];
			CMD_UP_MOVE: begin
				h_we    = 1'b1;
				h_wdata = h_rd_q;
				p_we    = 1'b1;
				p_waddr = h_rd_q.id;
			end
			CMD_DN_MOVE: begin
				h_we    = 1'b1;
				h_wdata = best_q;
				p_we    = 1'b1;
				p_waddr = best_q.id;
			end
			CMD_PLACE: begin
				h_we = 1'b1;
				p_we = 1'b1;
			end
			default: h_raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			heap_mem[h_waddr] <= h_wdata;
		end
		h_rd_q <= heap_mem[h_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			pos_mem[p_waddr] <= p_wdata;
		end
		p_rd_q <= pos_mem[in_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			res_ok_q <= 1'b0;
			moved_q  <= 1'b0;
		end else begin
			case (cmd.code)
				CMD_LOAD: begin
					res_ok_q <= 1'b0;
					moved_q  <= 1'b0;
				end
				CMD_INS: fill_q <= fill_q + FW'(1);
				CMD_EXT: begin
					fill_q   <= last_w;
					res_ok_q <= 1'b1;
				end
				CMD_REM:     fill_q  <= last_w;
				CMD_UP_MOVE: moved_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_LOAD: req_q <= in_data;
			CMD_LOOK: begin
				slot_q <= p_rd_q;
				root_q <= h_rd_q;
			end
			CMD_INS: begin
				cur_q  <= ins_ent;
				slot_q <= fill_q[PW-1:0];
			end
			CMD_EXT: begin
				cur_q  <= h_rd_q;
				slot_q <= '0;
			end
			CMD_REM_LD:  cur_q  <= h_rd_q;
			CMD_UP_MOVE: slot_q <= parent;
			CMD_DN_L: begin
				best_q     <= h_rd_q;
				best_idx_q <= left_w[PW-1:0];
			end
			CMD_DN_R: begin
				if (h_rd_q.key < best_q.key) begin
					best_q     <= h_rd_q;
					best_idx_q <= right_w[PW-1:0];
				end
			end
			CMD_DN_MOVE: slot_q <= best_idx_q;
			default: ;
		endcase
	end

	logic [16:0] root_id_w;
	logic [63:0] root_key_w;
	logic [31:0] fill_out_w;

	assign root_id_w  = 17'(root_q.id);
	assign root_key_w = 64'(root_q.key);
	assign fill_out_w = 32'(fill_q);

	always_ff @(posedge clk) begin
		if (cmd.code == CMD_FIN) begin
			out_q.out_id      <= res_ok_q ? root_id_w[7:0] : '0;
			out_q.out_key     <= res_ok_q ? root_key_w[31:0] : '0;
			out_q.status      <= cmd.status;
			out_q.entry_count <= fill_out_w[8:0];
		end
	end

	assign out_data = out_q;

	always_comb begin
		sts.op            = req_q.opcode;
		sts.id_ok         = req_id_w < 17'(ID_SPACE);
		sts.present       = sts.id_ok && (slot_w < fill_w) && (h_rd_q.id == req_idx);
		sts.full          = fill_q == FW'(CAPACITY);
		sts.empty         = fill_q == '0;
		sts.last_zero     = fill_q == FW'(1);
		sts.slot_lt_last  = (slot_w + CW'(1)) < fill_w;
		sts.slot_zero     = slot_q == '0;
		sts.moved         = moved_q;
		sts.cur_lt_rd     = cur_q.key < h_rd_q.key;
		sts.left_lt_fill  = left_w < fill_w;
		sts.right_lt_fill = right_w < fill_w;
		sts.best_lt_cur   = best_q.key < cur_q.key;
	end

endmodule

[src/ibmh_ctrl.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap controller
// Sequences lookup, error checks, sift-up, sift-down and the response.
// ----------------------------------------------------------------------------
module ibmh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ibmh_pkg::dp_sts_t  sts,
	output ibmh_pkg::dp_cmd_t  cmd
);
	import ibmh_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOOK  = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_REMRD = 4'd3;
	localparam logic [3:0] S_UPREQ = 4'd4;
	localparam logic [3:0] S_UPCMP = 4'd5;
	localparam logic [3:0] S_DNREQ = 4'd6;
	localparam logic [3:0] S_DNL   = 4'd7;
	localparam logic [3:0] S_DNR   = 4'd8;
	localparam logic [3:0] S_DNCMP = 4'd9;
	localparam logic [3:0] S_PLACE = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [2:0] sts_q;
	logic [2:0] sts_d;
	logic       out_valid_q;
	logic       out_load;
	logic       down_next;

	// A remove whose sift-up moved nothing continues with a sift-down.
	assign down_next = (sts.op == OP_REMOVE) && !sts.moved;

	always_comb begin
		state_d    = state_q;
		sts_d      = sts_q;
		cmd.code   = CMD_NOP;
		cmd.status = sts_q;
		out_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = CMD_LOAD;
					sts_d    = ST_OK;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.code = CMD_LOOK;
				state_d  = S_CHK;
			end
			S_CHK: begin
				state_d = S_FIN;
				case (sts.op)
					OP_INSERT: begin
						if (!sts.id_ok) begin
							sts_d = ST_ABSENT;
						end else if (sts.present) begin
							sts_d = ST_DUP;
						end else if (sts.full) begin
							sts_d = ST_FULL;
						end else begin
							cmd.code = CMD_INS;
							state_d  = S_UPREQ;
						end
					end
					OP_EXTRACT: begin
						if (sts.empty) begin
							sts_d = ST_EMPTY;
						end else begin
							cmd.code = CMD_EXT;
							state_d  = sts.last_zero ? S_FIN : S_DNREQ;
						end
					end
					OP_REMOVE: begin
						if (sts.present) begin
							cmd.code = CMD_REM;
							state_d  = sts.slot_lt_last ? S_REMRD : S_FIN;
						end else begin
							sts_d = ST_ABSENT;
						end
					end
					default: sts_d = ST_OK;
				endcase
			end
			S_REMRD: begin
				cmd.code = CMD_REM_LD;
				state_d  = S_UPREQ;
			end
			S_UPREQ: begin
				if (sts.slot_zero) begin
					state_d = down_next ? S_DNREQ : S_PLACE;
				end else begin
					cmd.code = CMD_UP_REQ;
					state_d  = S_UPCMP;
				end
			end
			S_UPCMP: begin
				if (sts.cur_lt_rd) begin
					cmd.code = CMD_UP_MOVE;
					state_d  = S_UPREQ;
				end else begin
					state_d = down_next ? S_DNREQ : S_PLACE;
				end
			end
			S_DNREQ: begin
				if (sts.left_lt_fill) begin
					cmd.code = CMD_DN_REQ;
					state_d  = S_DNL;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_DNL: begin
				cmd.code = CMD_DN_L;
				state_d  = sts.right_lt_fill ? S_DNR : S_DNCMP;
			end
			S_DNR: begin
				cmd.code = CMD_DN_R;
				state_d  = S_DNCMP;
			end
			S_DNCMP: begin
				if (sts.best_lt_cur) begin
					cmd.code = CMD_DN_MOVE;
					state_d  = S_DNREQ;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.code = CMD_PLACE;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.code = CMD_FIN;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sts_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sts_q   <= sts_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

[src/indexed_binary_min_heap_top.sv]
// ----------------------------------------------------------------------------
// Indexed binary min-heap priority queue
// Insert, extract-minimum and remove-by-id on a heap of (id, key) entries
// with a position map per id.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | opcode, node_id, node_key
// out     | output    | out_valid/out_stall| out_id, out_key, status, entry_count
//
// One request at a time. An error, a no-op, an extract of the only entry or a remove
// of the last slot needs no sift; an insert sifts up, an extract sifts down, and a
// remove sifts up and, when that moves nothing, sifts down. Every heap read goes
// through the single heap read port. Presence is checked through the position map
// and the heap, so reset needs no clearing pass. A stalled response holds the next
// request off until the output register frees.
// ----------------------------------------------------------------------------
module indexed_binary_min_heap_top #(
	parameter int CAPACITY  = 256,
	parameter int ID_SPACE  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ibmh_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output ibmh_pkg::rsp_t out_data
);
	import ibmh_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	ibmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ibmh_dp #(
		.CAPACITY  (CAPACITY),
		.ID_SPACE  (ID_SPACE),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

[src/ibmh_chk.sv]
// ----------------------------------------------------------------------------
// Indexed min-heap port checker
// Watches the top level's ports and checks response and handshake rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ibmh_chk #(
	parameter int CAPACITY = 256
) (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input ibmh_pkg::req_t in_data,
	input logic           out_valid,
	input logic           out_stall,
	input ibmh_pkg::rsp_t out_data
);
	import ibmh_pkg::*;

	// A stalled response must hold its payload.
	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

	`ASSERT_CLK_MSG(a_status_code, out_valid |-> (out_data.status == ST_OK ||
		out_data.status == ST_EMPTY || out_data.status == ST_FULL ||
		out_data.status == ST_ABSENT || out_data.status == ST_DUP), "bad status code")

	// An error response carries a zero id and key.
	`ASSERT_CLK_MSG(a_err_zero, out_valid && out_data.status != ST_OK |->
		out_data.out_id == 8'd0 && out_data.out_key == 32'd0, "error response carries data")

	`ASSERT_CLK_MSG(a_count_cap, out_valid |-> 32'(out_data.entry_count) <= 32'(CAPACITY),
		"entry count above capacity")

	// One request is worked on at a time.
	`ASSERT_CLK(a_one_req, in_valid && !in_stall |=> in_stall)

endmodule

bind indexed_binary_min_heap_top ibmh_chk #(.CAPACITY(CAPACITY)) u_ibmh_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

[tb/indexed_binary_min_heap_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed min-heap testbench
// Drives insert, extract-minimum, remove-by-id and unused-opcode requests with
// random gaps and output stalls, predicts each response with a behavioral heap,
// and compares every response field by field in arrival order.
// ----------------------------------------------------------------------------
module indexed_binary_min_heap_top_test;
	import ibmh_pkg::*;

	localparam int CAP       = 256;
	localparam int IDS       = 256;
	localparam int MAX_CYCLE = 400000;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;

	indexed_binary_min_heap_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Behavioral heap state.
	logic [7:0]  hp_id [CAP];
	logic [31:0] hp_key [CAP];
	int          id_slot [IDS];
	bit          id_in [IDS];
	int          fill;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];

	int  send_idle_pct, recv_idle_pct;
	bit  hold_recv;
	int  hold_left;
	bit  drain_pause;
	bit  stim_done;
	bit  in_acc;
	int  n_sent, n_rcvd, n_err, n_ext_ok, n_status[5];
	int  cycle_cnt;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void heap_put(int s, logic [7:0] id, logic [31:0] k);
		hp_id[s] = id;
		hp_key[s] = k;
		id_slot[id] = s;
	endfunction

	function automatic void heap_swap(int a, int b);
		logic [7:0]  ia;
		logic [31:0] ka;
		ia = hp_id[a];
		ka = hp_key[a];
		heap_put(a, hp_id[b], hp_key[b]);
		heap_put(b, ia, ka);
	endfunction

	function automatic void heap_up(int s);
		int p;
		while (s > 0) begin
			p = (s - 1) / 2;
			if (!(hp_key[s] < hp_key[p])) break;
			heap_swap(s, p);
			s = p;
		end
	endfunction

	function automatic void heap_down(int s);
		int l, r, b;
		forever begin
			l = 2 * s + 1;
			r = l + 1;
			if (l >= fill) break;
			b = l;
			if (r < fill && hp_key[r] < hp_key[l]) b = r;
			if (!(hp_key[b] < hp_key[s])) break;
			heap_swap(s, b);
			s = b;
		end
	endfunction

	function automatic rsp_t heap_apply(req_t rq);
		rsp_t rs;
		int   s, last;
		rs = '0;
		rs.status = ST_OK;
		case (rq.opcode)
			OP_INSERT: begin
				if (id_in[rq.node_id]) rs.status = ST_DUP;
				else if (fill >= CAP) rs.status = ST_FULL;
				else begin
					heap_put(fill, rq.node_id, rq.node_key);
					id_in[rq.node_id] = 1'b1;
					fill++;
					heap_up(fill - 1);
				end
			end
			OP_EXTRACT: begin
				if (fill == 0) rs.status = ST_EMPTY;
				else begin
					rs.out_id = hp_id[0];
					rs.out_key = hp_key[0];
					id_in[hp_id[0]] = 1'b0;
					fill--;
					if (fill > 0) begin
						heap_put(0, hp_id[fill], hp_key[fill]);
						heap_down(0);
					end
				end
			end
			OP_REMOVE: begin
				if (!id_in[rq.node_id]) rs.status = ST_ABSENT;
				else begin
					s = id_slot[rq.node_id];
					last = fill - 1;
					id_in[rq.node_id] = 1'b0;
					fill = last;
					if (s < last) begin
						heap_put(s, hp_id[last], hp_key[last]);
						heap_up(s);
						heap_down(s);
					end
				end
			end
			default: ;
		endcase
		rs.entry_count = fill[8:0];
		return rs;
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [7:0] id, logic [31:0] k);
		req_t r;
		r.opcode = op;
		r.node_id = id;
		r.node_key = k;
		return r;
	endfunction

	// Keys drawn from a narrow range often so that equal keys occur.
	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Sender: take the next request at the falling edge once the last one is accepted.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_acc) begin
			if (pending_reqs.size() > 0 && !drain_pause
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_reqs.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with a long hold-off when asked.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			hold_left <= 0;
		end else if (hold_recv && hold_left == 0) begin
			hold_left <= 300;
			out_stall <= 1'b1;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			if (hold_left == 1) hold_left <= -1;
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Accepted requests feed the predictor; responses are checked in order.
	always @(posedge clk) begin
		rsp_t ex;
		if (arst_n) begin
			cycle_cnt <= cycle_cnt + 1;
			in_acc <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_rsps.push_back(heap_apply(in_data));
				n_sent++;
			end
			if (out_valid && !out_stall) begin
				n_rcvd++;
				if (expected_rsps.size() == 0) begin
					n_err++;
					if (n_err <= 10) $display("unexpected response %p", out_data);
				end else begin
					ex = expected_rsps.pop_front();
					if (out_data.status < 5) n_status[out_data.status]++;
					if (ex.status == ST_OK && out_data.out_key != 0) n_ext_ok++;
					if (out_data.out_id !== ex.out_id || out_data.out_key !== ex.out_key
							|| out_data.status !== ex.status
							|| out_data.entry_count !== ex.entry_count) begin
						n_err++;
						if (n_err <= 10)
							$display("mismatch at response %0d: expected %p, got %p",
								n_rcvd, ex, out_data);
					end
				end
			end
			if (cycle_cnt >= MAX_CYCLE) begin
				$display("timeout after %0d cycles", cycle_cnt);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int count);
		logic [7:0] id;
		int         r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			id = 8'($urandom_range(0, 255));
			if (r < 45) pending_reqs.push_back(make_req(OP_INSERT, id, rand_key()));
			else if (r < 70) pending_reqs.push_back(make_req(OP_EXTRACT, id, $urandom));
			else if (r < 95) pending_reqs.push_back(make_req(OP_REMOVE, id, $urandom));
			else pending_reqs.push_back(make_req(OP_UNUSED, id, $urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b1;
		send_idle_pct = 34;
		recv_idle_pct = 59;
		hold_recv = 1'b0;
		drain_pause = 1'b0;
		fill = 0;
		cycle_cnt = 0;
		foreach (id_in[i]) id_in[i] = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty extract, absent remove, extremes, duplicate,
		// equal keys, and removes of inner slots.
		pending_reqs.push_back(make_req(OP_EXTRACT, 8'd0, 32'd0));
		pending_reqs.push_back(make_req(OP_REMOVE, 8'd255, 32'd0));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd255, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd0, 32'd0));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd0, 32'd5));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd7, 32'd0));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd8, 32'h8000_0000));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd9, 32'd3));
		pending_reqs.push_back(make_req(OP_UNUSED, 8'hAA, 32'h5555_5555));
		pending_reqs.push_back(make_req(OP_REMOVE, 8'd9, 32'd0));
		pending_reqs.push_back(make_req(OP_REMOVE, 8'd0, 32'd0));
		pending_reqs.push_back(make_req(OP_EXTRACT, 8'd0, 32'd0));
		pending_reqs.push_back(make_req(OP_EXTRACT, 8'd0, 32'd0));
		pending_reqs.push_back(make_req(OP_EXTRACT, 8'd0, 32'd0));
		pending_reqs.push_back(make_req(OP_EXTRACT, 8'd0, 32'd0));
		wait_drained();

		// Fill to capacity while the receiver holds off, then insert a present id.
		hold_recv = 1'b1;
		for (int i = 0; i < CAP; i++)
			pending_reqs.push_back(make_req(OP_INSERT, i[7:0], rand_key()));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd0, 32'd1));
		wait_drained();
		hold_recv = 1'b0;
		// Insert of a fresh id into a full heap needs a removal first.
		pending_reqs.push_back(make_req(OP_REMOVE, 8'd100, 32'd0));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd100, 32'd2));
		pending_reqs.push_back(make_req(OP_INSERT, 8'd100, 32'd2));
		for (int i = 0; i < 32; i++)
			pending_reqs.push_back(make_req(OP_EXTRACT, 8'd0, 32'd0));
		wait_drained();

		// The sender stops mid-stream until every response is back.
		random_phase(34);
		repeat (60) @(posedge clk);
		drain_pause = 1'b1;
		while (in_valid || expected_rsps.size() > 0)
			@(posedge clk);
		drain_pause = 1'b0;
		wait_drained();
		send_idle_pct = 59;
		recv_idle_pct = 34;
		random_phase(34);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(30);
		wait_drained();
		repeat (100) @(posedge clk);

		$display("Sent %0d requests, checked %0d responses; statuses ok/empty/full/absent/dup:",
			n_sent, n_rcvd);
		$display("  %0d/%0d/%0d/%0d/%0d, including a full heap and long output stalls",
			n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
		if (n_err == 0 && expected_rsps.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d responses missing", n_err, expected_rsps.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/ibmh_pkg.sv
src/ibmh_dp.sv
src/ibmh_ctrl.sv
src/indexed_binary_min_heap_top.sv
src/ibmh_chk.sv
tb/indexed_binary_min_heap_top_test.sv
